>>> hw/rtl/epie_pkg.sv
// Shared types, constants and lookup functions for the edge pattern index encoder.
package epie_pkg;

  localparam int NUM_POS     = 12;
  localparam int NUM_TRACKED = 6;
  localparam int ID_W        = 4;
  localparam int IDS_W       = NUM_POS * ID_W;
  localparam int FLIP_W      = 6;
  localparam int CNT_W       = 4;
  localparam int COMB_W      = 10;
  localparam int LEHMER_W    = 10;
  localparam int BASE_W      = 20;
  localparam int KEY_W       = 26;

  localparam logic [ID_W-1:0]   TRACK_MIN  = 4'd6;
  localparam logic [CNT_W-1:0]  CNT_FULL   = 4'd6;
  localparam logic [BASE_W-1:0] PERM_SPACE = 20'd720;

  // Item state carried from cell to cell
  typedef struct packed {
    logic [IDS_W-1:0]                ids;     // unconsumed identities, next one in low nibble
    logic [FLIP_W-1:0]               flips;
    logic [CNT_W-1:0]                cnt;     // tracked edges seen so far
    logic [COMB_W-1:0]               comb;    // combination rank so far
    logic [LEHMER_W-1:0]             lehmer;  // Lehmer rank so far
    logic [NUM_TRACKED-1:0][ID_W-1:0] perm;   // tracked identities less six, in order
  } item_t;

  // C(n, r) for n 0..12, r 0..5; zero where r > n
  function automatic logic [COMB_W-1:0] binom(input logic [3:0] n, input logic [2:0] r);
    logic [5:0][COMB_W-1:0] row;
    row = '0;
    unique case (n)
      4'd0:  row = {10'd0,   10'd0,   10'd0,   10'd0,   10'd0,  10'd1};
      4'd1:  row = {10'd0,   10'd0,   10'd0,   10'd0,   10'd1,  10'd1};
      4'd2:  row = {10'd0,   10'd0,   10'd0,   10'd1,   10'd2,  10'd1};
      4'd3:  row = {10'd0,   10'd0,   10'd1,   10'd3,   10'd3,  10'd1};
      4'd4:  row = {10'd0,   10'd1,   10'd4,   10'd6,   10'd4,  10'd1};
      4'd5:  row = {10'd1,   10'd5,   10'd10,  10'd10,  10'd5,  10'd1};
      4'd6:  row = {10'd6,   10'd15,  10'd20,  10'd15,  10'd6,  10'd1};
      4'd7:  row = {10'd21,  10'd35,  10'd35,  10'd21,  10'd7,  10'd1};
      4'd8:  row = {10'd56,  10'd70,  10'd56,  10'd28,  10'd8,  10'd1};
      4'd9:  row = {10'd126, 10'd126, 10'd84,  10'd36,  10'd9,  10'd1};
      4'd10: row = {10'd252, 10'd210, 10'd120, 10'd45,  10'd10, 10'd1};
      4'd11: row = {10'd462, 10'd330, 10'd165, 10'd55,  10'd11, 10'd1};
      4'd12: row = {10'd792, 10'd495, 10'd220, 10'd66,  10'd12, 10'd1};
      default: row = '0;
    endcase
    if (r <= 3'd5) begin
      binom = row[r];
    end else begin
      binom = '0;
    end
  endfunction

  // k! for k 0..5
  function automatic logic [6:0] fact(input logic [2:0] k);
    unique case (k)
      3'd0:    fact = 7'd1;
      3'd1:    fact = 7'd1;
      3'd2:    fact = 7'd2;
      3'd3:    fact = 7'd6;
      3'd4:    fact = 7'd24;
      3'd5:    fact = 7'd120;
      default: fact = 7'd0;
    endcase
  endfunction

endpackage

>>> hw/rtl/epie_cell.sv
// One position cell: consumes one edge identity and updates the running ranks.
module epie_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [3:0]           pos_i,
  input  logic                 up_valid,
  input  epie_pkg::item_t      up_item,
  output logic                 take_up,
  input  logic                 take_dn,
  output logic                 dn_valid,
  output epie_pkg::item_t      dn_item
);

  logic                  valid_r;
  epie_pkg::item_t       item_r;
  epie_pkg::item_t       item_nxt;
  logic [3:0]            id;
  logic [3:0]            idn;
  logic                  tracked;
  logic                  room;
  logic [3:0]            n_sel;
  logic [2:0]            r_sel;
  logic [epie_pkg::LEHMER_W-1:0] lh_add;

  assign take_up = !valid_r || take_dn;

  assign id      = up_item.ids[epie_pkg::ID_W-1:0];
  assign idn     = id - epie_pkg::TRACK_MIN;
  assign tracked = (id >= epie_pkg::TRACK_MIN);
  assign room    = (up_item.cnt < epie_pkg::CNT_FULL);
  assign n_sel   = 4'(epie_pkg::NUM_POS - 1) - pos_i;
  assign r_sel   = 3'(epie_pkg::CNT_FULL - 4'd1 - up_item.cnt);

  // weight of every earlier tracked identity greater than this one
  always_comb begin
    lh_add = '0;
    for (int k = 0; k < epie_pkg::NUM_TRACKED; k++) begin
      if ((4'(k) < up_item.cnt) && (up_item.perm[k] > idn)) begin
        lh_add = lh_add
               + epie_pkg::LEHMER_W'(epie_pkg::fact(3'(epie_pkg::NUM_TRACKED - 1 - k)));
      end
    end
  end

  always_comb begin
    item_nxt     = up_item;
    item_nxt.ids = {{epie_pkg::ID_W{1'b0}}, up_item.ids[epie_pkg::IDS_W-1:epie_pkg::ID_W]};
    if (tracked) begin
      item_nxt.cnt = up_item.cnt + 4'd1;
      if (room) begin
        item_nxt.lehmer = up_item.lehmer + lh_add;
        for (int k = 0; k < epie_pkg::NUM_TRACKED; k++) begin
          if (4'(k) == up_item.cnt) begin
            item_nxt.perm[k] = idn;
          end
        end
      end
    end else if (room) begin
      item_nxt.comb = up_item.comb + epie_pkg::binom(n_sel, r_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_up) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_up) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

>>> hw/rtl/epie_out.sv
// Output stage: combines both ranks with the flip bits into the key, registered.
module epie_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  input  epie_pkg::item_t              up_item,
  output logic                         take_up,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [epie_pkg::KEY_W-1:0]   out_key,
  output logic                         out_invalid
);

  logic                             valid_r;
  logic [epie_pkg::KEY_W-1:0]       key_r;
  logic                             invalid_r;
  logic [epie_pkg::KEY_W-1:0]       key_nxt;
  logic                             invalid_nxt;
  logic [epie_pkg::BASE_W-1:0]      base;
  logic [epie_pkg::FLIP_W-1:0]      flip_rev;

  assign take_up = !valid_r || out_ready;

  assign base = epie_pkg::BASE_W'(up_item.comb) * epie_pkg::PERM_SPACE
              + epie_pkg::BASE_W'(up_item.lehmer);

  // flip bit 0 lands in the top flip bit of the key; the bit order is reversed
  always_comb begin
    for (int k = 0; k < epie_pkg::FLIP_W; k++) begin
      flip_rev[epie_pkg::FLIP_W-1-k] = up_item.flips[k];
    end
  end

  always_comb begin
    invalid_nxt = (up_item.cnt != epie_pkg::CNT_FULL);
    key_nxt     = invalid_nxt ? '0 : {base, flip_rev};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_up) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_up) begin
      key_r     <= key_nxt;
      invalid_r <= invalid_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_key     = key_r;
  assign out_invalid = invalid_r;

endmodule

>>> hw/rtl/edge_pattern_index_encoder_core.sv
// Top level of the edge pattern index encoder: twelve position cells and an output stage.
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_ready, in_edge_ids, in_flip_bits | in
//  result  | out_valid, out_ready, out_key, out_invalid | out
//
// One item enters per cycle while in_ready is high; each result passes through
// the twelve position cells in order and then the key stage.
// Every cell handles one position of one item a cycle unless the next stage stalls;
// the key stage does the times-720 and add.
// Reset (synchronous, rst_n low) clears only the valid flags of the chain.
// Each stage holds its item only while the next one is full and stalled,
// so bubbles close up and input is taken while a result still waits.
module edge_pattern_index_encoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_edge_ids,
  input  logic [5:0]  in_flip_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [25:0] out_key,
  output logic        out_invalid
);

  localparam int N = epie_pkg::NUM_POS;

  // stage k feeds cell k; stage N feeds the key stage
  logic            st_valid [0:N];
  epie_pkg::item_t st_item  [0:N];
  logic            st_take  [0:N];
  epie_pkg::item_t in_item;

  // fresh item: no edges counted, ranks at zero
  always_comb begin
    in_item        = '0;
    in_item.ids    = in_edge_ids;
    in_item.flips  = in_flip_bits;
  end
  assign st_item[0]  = in_item;
  assign st_valid[0] = in_valid;
  assign in_ready    = st_take[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    epie_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .pos_i    (4'(i)),
      .up_valid (st_valid[i]),
      .up_item  (st_item[i]),
      .take_up  (st_take[i]),
      .take_dn  (st_take[i+1]),
      .dn_valid (st_valid[i+1]),
      .dn_item  (st_item[i+1])
    );
  end

  epie_out u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (st_valid[N]),
    .up_item     (st_item[N]),
    .take_up     (st_take[N]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_key     (out_key),
    .out_invalid (out_invalid)
  );

  // an empty result register frees the whole chain
  a_ready_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_invalid_key_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_key == 26'd0))
    else $error("invalid item with non-zero key");

  a_key_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invalid) |-> (out_key <= 26'd42577919))
    else $error("key out of range");

endmodule
